[design/uida_pkg.sv]
// shared constants, types and codes of the unique id allocator
`default_nettype none

package uida_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ID_LIMIT    = 128;

    localparam int QID_W   = 7;
    localparam int GIVEN_W = 7;
    localparam int STAT_W  = 2;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int MID_W = $clog2(ID_LIMIT);
    localparam int IDV_W = $clog2(ID_LIMIT + 2);

    localparam int FULL_LIMIT = (MAX_ENTRIES < ID_LIMIT - 1) ? MAX_ENTRIES : ID_LIMIT - 1;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic ACT_ALLOC  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_MISS = 2'd2;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_LOOKUP,
        CMD_MISS
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [QID_W-1:0] qid;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PROBE,
        ST_BOUND,
        ST_COMMIT,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

[design/uida_if.sv]
// request and response channel interfaces of the unique id allocator
`default_nettype none

interface uida_req_if
    import uida_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             action;
    logic [QID_W-1:0] query_id;

    modport source (output valid, action, query_id, input ready);
    modport sink   (input valid, action, query_id, output ready);
endinterface

interface uida_rsp_if
    import uida_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [GIVEN_W-1:0] given_id;

    modport source (output valid, status, given_id, input ready);
    modport sink   (input valid, status, given_id, output ready);
endinterface

`default_nettype wire

[design/unique_id_allocator.sv]
// top level of the unique id allocator
`default_nettype none

// Hands out ids 1..127 (up to 64 of them, refusing with status full after
// that) and answers membership lookups. The front end takes one request per
// cycle into a two-entry command queue while the back end works, stalling
// when the queue is full; the back end handles one command at a time against
// a 64-entry id table with one registered read port. A lookup walks the used
// part of the table. An allocation whose next id lies below the known bound
// needs no rescan; otherwise it rescans the table for each taken id it
// skips and then once more to find the next bound. Out-of-range lookups and
// refused allocations skip the table. There is no clearing pass after reset.
module unique_id_allocator
    import uida_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    uida_req_if.sink   req,
    uida_rsp_if.source rsp
);

    logic push_valid;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    uida_front u_front (
        .req        (req),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    uida_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop)
    );

    uida_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

[design/uida_front.sv]
// front end: accepts requests and classifies them into commands
`default_nettype none

module uida_front
    import uida_pkg::*;
(
    uida_req_if.sink req,
    input  wire logic q_full,
    output logic      push_valid,
    output cmd_t      push_cmd
);

    logic in_range;

    assign in_range = (IDV_W'(req.query_id) != '0) &&
                      (IDV_W'(req.query_id) < IDV_W'(ID_LIMIT));

    assign req.ready  = !q_full;
    assign push_valid = req.valid && !q_full;

    always_comb
    begin
        push_cmd.qid = req.query_id;
        if (req.action == ACT_LOOKUP)
        begin
            push_cmd.op = in_range ? CMD_LOOKUP : CMD_MISS;
        end
        else
        begin
            push_cmd.op = CMD_ALLOC;
        end
    end

endmodule

`default_nettype wire

[design/uida_queue.sv]
// short command queue between front end and back end
`default_nettype none

module uida_queue
    import uida_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    input  wire cmd_t push_cmd,
    output logic      q_full,
    output logic      q_valid,
    output cmd_t      q_cmd,
    input  wire logic q_pop
);

    cmd_t              slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign q_full  = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_push = push_valid && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[design/uida_back.sv]
// back end: id table, scan sequencer and response register
`default_nettype none

module uida_back
    import uida_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      q_pop,
    uida_rsp_if.source rsp
);

    logic [MID_W-1:0] mem_q [MAX_ENTRIES];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDV_W-1:0]   last_reg, last_next;
    logic [IDV_W-1:0]   bound_reg, bound_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [MID_W-1:0]   rd_data_reg;
    logic [IDV_W-1:0]   cand_reg, cand_next;
    logic [IDV_W-1:0]   nb_reg, nb_next;
    logic [QID_W-1:0]   qid_reg, qid_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [GIVEN_W-1:0] res_id_reg, res_id_next;
    logic [STAT_W-1:0]  rsp_status_reg, rsp_status_next;
    logic [GIVEN_W-1:0] rsp_id_reg, rsp_id_next;

    logic               mem_we;
    logic               scan_issue;
    logic               scan_done;
    logic [IDV_W-1:0]   rd_val;
    logic [IDV_W-1:0]   cand_inc;
    logic [IDV_W-1:0]   probe_inc;

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = rsp_status_reg;
    assign rsp.given_id = rsp_id_reg;

    assign scan_issue = (issue_reg < count_reg);
    assign scan_done  = !scan_issue && !rd_vld_reg;
    assign rd_val     = IDV_W'(rd_data_reg);
    assign cand_inc   = last_reg + IDV_W'(1);
    assign probe_inc  = cand_reg + IDV_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        bound_next      = bound_reg;
        issue_next      = issue_reg;
        rd_vld_next     = 1'b0;
        cand_next       = cand_reg;
        nb_next         = nb_reg;
        qid_next        = qid_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_id_next     = rsp_id_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    qid_next   = q_cmd.qid;
                    issue_next = '0;
                    unique case (q_cmd.op)
                        CMD_LOOKUP:
                        begin
                            state_next = ST_LOOKUP;
                        end
                        CMD_ALLOC:
                        begin
                            if (count_reg >= CNT_W'(FULL_LIMIT))
                            begin
                                res_status_next = STATUS_FULL;
                                res_id_next     = '0;
                                state_next      = ST_RESULT;
                            end
                            else if (cand_inc >= IDV_W'(ID_LIMIT))
                            begin
                                cand_next  = IDV_W'(1);
                                state_next = ST_PROBE;
                            end
                            else if (cand_inc >= bound_reg)
                            begin
                                cand_next  = cand_inc;
                                state_next = ST_PROBE;
                            end
                            else
                            begin
                                cand_next  = cand_inc;
                                state_next = ST_COMMIT;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_MISS;
                            res_id_next     = '0;
                            state_next      = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_LOOKUP:
            begin
                if (rd_vld_reg && (rd_val == IDV_W'(qid_reg)))
                begin
                    res_status_next = STATUS_OK;
                    res_id_next     = GIVEN_W'(qid_reg);
                    state_next      = ST_RESULT;
                end
                else if (scan_done)
                begin
                    res_status_next = STATUS_MISS;
                    res_id_next     = '0;
                    state_next      = ST_RESULT;
                end
                else if (scan_issue)
                begin
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                end
            end

            ST_PROBE:
            begin
                // candidate taken: step on and rescan from the first entry
                if (rd_vld_reg && (rd_val == cand_reg))
                begin
                    cand_next  = (probe_inc >= IDV_W'(ID_LIMIT)) ? IDV_W'(1) : probe_inc;
                    issue_next = '0;
                end
                else if (scan_done)
                begin
                    issue_next = '0;
                    nb_next    = IDV_W'(ID_LIMIT);
                    state_next = ST_BOUND;
                end
                else if (scan_issue)
                begin
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                end
            end

            ST_BOUND:
            begin
                if (rd_vld_reg && (rd_val > cand_reg) && (rd_val < nb_reg))
                begin
                    nb_next = rd_val;
                end
                if (scan_done)
                begin
                    bound_next = nb_reg;
                    state_next = ST_COMMIT;
                end
                else if (scan_issue)
                begin
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                end
            end

            ST_COMMIT:
            begin
                mem_we          = 1'b1;
                count_next      = count_reg + 1'b1;
                last_next       = cand_reg;
                res_status_next = STATUS_OK;
                res_id_next     = GIVEN_W'(cand_reg);
                state_next      = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_id_next     = res_id_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_reg      <= IDV_W'(ID_LIMIT);
            bound_reg     <= IDV_W'(ID_LIMIT);
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            bound_reg     <= bound_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg       <= cand_next;
        nb_reg         <= nb_next;
        qid_reg        <= qid_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        rsp_status_reg <= rsp_status_next;
        rsp_id_reg     <= rsp_id_next;
    end

    // id table, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_q[count_reg[IDX_W-1:0]] <= cand_reg[MID_W-1:0];
        end
        rd_data_reg <= mem_q[issue_reg[IDX_W-1:0]];
    end

endmodule

`default_nettype wire
